/* hdl/ktssr_pkg.sv */
// ktssr_pkg: shared constants, register indexes, sequencer states and divider
// handshake types for the knowledge tracing error evaluator.
// No dependencies; used by ktssr_div and knowledge_tracing_ssr_evaluator.
`default_nettype none

package ktssr_pkg;

    // default fixed-point widths
    localparam int PROB_BITS_DEF = 16;
    localparam int ACC_BITS_DEF  = 40;

    // fixed field widths
    localparam int STUDENT_W  = 24;
    localparam int BOUND_W    = 40;
    localparam int IN_TDATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRIOR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEARN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLIP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GUESS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND = 3'd4;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PK,
        ST_PU,
        ST_PRED,
        ST_RES,
        ST_SQ,
        ST_ACC,
        ST_CMP,
        ST_MS,
        ST_MG,
        ST_DEN,
        ST_DGO,
        ST_DIV,
        ST_GAIN,
        ST_UPD,
        ST_DONE
    } state_t;

    // divider control and status
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

/* hdl/knowledge_tracing_ssr_evaluator.sv */
// knowledge_tracing_ssr_evaluator: one row at a time through a shared multiplier
// and an iterative divider. A row ignored after exceeded goes straight to the
// result, a row that first passes the bound ends at the compare, a right answer
// starts the divider at once and a wrong one first forms its slip and guess terms;
// the next row is taken only once its result is loaded into the output register.
// Reset (aresetn low, synchronous) clears state, config, run state, valid; bound all ones.
`default_nettype none

module knowledge_tracing_ssr_evaluator #(
    parameter int PROB_BITS = ktssr_pkg::PROB_BITS_DEF,
    parameter int ACC_BITS  = ktssr_pkg::ACC_BITS_DEF
) (
    input  wire                                    aclk,
    input  wire                                    aresetn,
    // input rows
    input  wire                                    s_tvalid,
    output logic                                   s_tready,
    input  wire  [ktssr_pkg::IN_TDATA_W-1:0]       s_tdata,  // student[23:0], answered_right[24]
    input  wire  [0:0]                             s_tuser,  // first_row
    // results
    output logic                                   m_tvalid,
    input  wire                                    m_tready,
    output logic [((PROB_BITS+1+ACC_BITS+7)/8)*8-1:0] m_tdata, // predicted, then error_sum
    output logic [0:0]                             m_tuser,  // exceeded
    // configuration writes
    input  wire                                    cfg_valid,
    output logic                                   cfg_ready,
    input  wire  [ktssr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [ktssr_pkg::BOUND_W-1:0]          cfg_data
);

    localparam int P        = PROB_BITS;
    localparam int PW       = 2 * PROB_BITS + 1;
    localparam int OUT_W    = ((PROB_BITS + 1 + ACC_BITS + 7) / 8) * 8;
    localparam int SUM_W    = ((ACC_BITS > PROB_BITS + 1) ? ACC_BITS : PROB_BITS + 1) + 1;
    localparam int CMP_W    = (ACC_BITS > ktssr_pkg::BOUND_W) ? ACC_BITS : ktssr_pkg::BOUND_W;
    localparam logic [P:0]  ONE  = (P+1)'(1) << P;
    localparam logic [PW-1:0] HALF = PW'(1) << (P - 1);

    // configuration registers
    logic [P-1:0]                     prior_reg;
    logic [P-1:0]                     learn_reg;
    logic [P-1:0]                     slip_reg;
    logic [P-1:0]                     guess_reg;
    logic [ktssr_pkg::BOUND_W-1:0]    bound_reg;

    // run state
    logic [ktssr_pkg::STUDENT_W-1:0]  last_reg;
    logic [P:0]                       level_reg;
    logic [ACC_BITS-1:0]              err_reg;
    logic                             over_reg;

    // row registers
    logic [ktssr_pkg::STUDENT_W-1:0]  student_reg;
    logic                             right_reg;
    logic [PW-1:0]                    prod_reg;
    logic [PW-1:0]                    pk_reg;
    logic [PW-1:0]                    sum_reg;
    logic [PW-1:0]                    num_reg;
    logic [PW-1:0]                    den_reg;
    logic [P:0]                       pred_reg;

    // output register
    logic                             m_valid_reg;
    logic [P:0]                       m_pred_reg;
    logic [ACC_BITS-1:0]              m_err_reg;
    logic                             m_exc_reg;

    ktssr_pkg::state_t                state_reg;
    ktssr_pkg::state_t                state_next;

    // sequencer outputs
    logic [P:0]                       mul_a;
    logic [P:0]                       mul_b;
    logic [2*P+1:0]                   mul_full;
    logic                             in_take;
    logic                             out_load;
    ktssr_pkg::div_ctrl_t             div_ctrl;
    ktssr_pkg::div_stat_t             div_stat;
    logic [P:0]                       quot;

    // datapath helpers
    logic [PW-1:0]                    pred_full;
    logic [PW-1:0]                    round_full;
    logic [P:0]                       resid;
    logic [SUM_W-1:0]                 acc_sum;
    logic [ACC_BITS-1:0]              acc_sat;
    logic                             acc_over;
    logic [P+1:0]                     new_level;
    logic [P:0]                       new_level_cap;

    assign cfg_ready = 1'b1;

    // configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prior_reg <= '0;
            learn_reg <= '0;
            slip_reg  <= '0;
            guess_reg <= '0;
            bound_reg <= '1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                ktssr_pkg::REG_PRIOR: prior_reg <= cfg_data[P-1:0];
                ktssr_pkg::REG_LEARN: learn_reg <= cfg_data[P-1:0];
                ktssr_pkg::REG_SLIP:  slip_reg  <= cfg_data[P-1:0];
                ktssr_pkg::REG_GUESS: guess_reg <= cfg_data[P-1:0];
                ktssr_pkg::REG_BOUND: bound_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // shared fractional divider
    ktssr_div #(
        .PROB_BITS (PROB_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (div_ctrl),
        .num     (num_reg),
        .den     (den_reg),
        .stat    (div_stat),
        .quot    (quot)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ktssr_pkg::ST_IDLE:  if (s_tvalid) state_next = ktssr_pkg::ST_CHECK;
            ktssr_pkg::ST_CHECK: state_next = over_reg ? ktssr_pkg::ST_DONE : ktssr_pkg::ST_PK;
            ktssr_pkg::ST_PK:    state_next = ktssr_pkg::ST_PU;
            ktssr_pkg::ST_PU:    state_next = ktssr_pkg::ST_PRED;
            ktssr_pkg::ST_PRED:  state_next = ktssr_pkg::ST_RES;
            ktssr_pkg::ST_RES:   state_next = ktssr_pkg::ST_SQ;
            ktssr_pkg::ST_SQ:    state_next = ktssr_pkg::ST_ACC;
            ktssr_pkg::ST_ACC:   state_next = ktssr_pkg::ST_CMP;
            ktssr_pkg::ST_CMP: begin
                if (CMP_W'(err_reg) > CMP_W'(bound_reg)) begin
                    state_next = ktssr_pkg::ST_DONE;
                end else if (right_reg) begin
                    state_next = ktssr_pkg::ST_DGO;
                end else begin
                    state_next = ktssr_pkg::ST_MS;
                end
            end
            ktssr_pkg::ST_MS:    state_next = ktssr_pkg::ST_MG;
            ktssr_pkg::ST_MG:    state_next = ktssr_pkg::ST_DEN;
            ktssr_pkg::ST_DEN:   state_next = ktssr_pkg::ST_DGO;
            ktssr_pkg::ST_DGO:   state_next = ktssr_pkg::ST_DIV;
            ktssr_pkg::ST_DIV:   if (div_stat.done) state_next = ktssr_pkg::ST_GAIN;
            ktssr_pkg::ST_GAIN:  state_next = ktssr_pkg::ST_UPD;
            ktssr_pkg::ST_UPD:   state_next = ktssr_pkg::ST_DONE;
            ktssr_pkg::ST_DONE:  if (!m_valid_reg || m_tready) state_next = ktssr_pkg::ST_IDLE;
            default:             state_next = ktssr_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: multiplier operands, divider start, handshakes
    always_comb begin
        mul_a          = '0;
        mul_b          = '0;
        div_ctrl.start = 1'b0;
        s_tready       = 1'b0;
        out_load       = 1'b0;
        unique case (state_reg)
            ktssr_pkg::ST_IDLE: s_tready = 1'b1;
            ktssr_pkg::ST_PK: begin
                mul_a = level_reg;
                mul_b = ONE - (P+1)'(slip_reg);
            end
            ktssr_pkg::ST_PU: begin
                mul_a = ONE - level_reg;
                mul_b = (P+1)'(guess_reg);
            end
            ktssr_pkg::ST_SQ: begin
                mul_a = resid;
                mul_b = resid;
            end
            ktssr_pkg::ST_MS: begin
                mul_a = level_reg;
                mul_b = (P+1)'(slip_reg);
            end
            ktssr_pkg::ST_MG: begin
                mul_a = ONE - level_reg;
                mul_b = ONE - (P+1)'(guess_reg);
            end
            ktssr_pkg::ST_DGO: div_ctrl.start = 1'b1;
            ktssr_pkg::ST_GAIN: begin
                mul_a = ONE - quot;
                mul_b = (P+1)'(learn_reg);
            end
            ktssr_pkg::ST_DONE: out_load = !m_valid_reg || m_tready;
            default: ;
        endcase
    end

    assign in_take  = s_tvalid && s_tready;
    assign mul_full = mul_a * mul_b;

    // rounding, residual, saturating sum and level update
    always_comb begin
        pred_full     = (sum_reg + HALF) >> P;
        round_full    = (prod_reg + HALF) >> P;
        resid         = right_reg ? (ONE - pred_reg) : pred_reg;
        acc_sum       = SUM_W'(err_reg) + SUM_W'(round_full[P:0]);
        acc_over      = (acc_sum[SUM_W-1:ACC_BITS] != '0);
        acc_sat       = acc_over ? '1 : acc_sum[ACC_BITS-1:0];
        new_level     = (P+2)'(quot) + (P+2)'(round_full[P:0]);
        new_level_cap = (new_level > (P+2)'(ONE)) ? ONE : new_level[P:0];
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ktssr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // shared product register
    always_ff @(posedge aclk) begin
        prod_reg <= mul_full[PW-1:0];
    end

    // run state updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg  <= '0;
            level_reg <= '0;
            err_reg   <= '0;
            over_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                ktssr_pkg::ST_IDLE: begin
                    if (in_take && s_tuser[0]) begin
                        last_reg  <= '0;
                        level_reg <= '0;
                        err_reg   <= '0;
                        over_reg  <= 1'b0;
                    end
                end
                ktssr_pkg::ST_CHECK: begin
                    if (!over_reg && (student_reg != last_reg)) begin
                        level_reg <= (P+1)'(prior_reg);
                        last_reg  <= student_reg;
                    end
                end
                ktssr_pkg::ST_ACC: err_reg <= acc_sat;
                ktssr_pkg::ST_CMP: begin
                    if (CMP_W'(err_reg) > CMP_W'(bound_reg)) over_reg <= 1'b1;
                end
                ktssr_pkg::ST_UPD: level_reg <= new_level_cap;
                default: ;
            endcase
        end
    end

    // row payload registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ktssr_pkg::ST_IDLE: begin
                if (in_take) begin
                    student_reg <= s_tdata[ktssr_pkg::STUDENT_W-1:0];
                    right_reg   <= s_tdata[ktssr_pkg::STUDENT_W];
                end
            end
            ktssr_pkg::ST_CHECK: pred_reg <= '0;
            ktssr_pkg::ST_PU:    pk_reg   <= prod_reg;
            ktssr_pkg::ST_PRED:  sum_reg  <= pk_reg + prod_reg;
            ktssr_pkg::ST_RES:   pred_reg <= pred_full[P:0];
            ktssr_pkg::ST_CMP: begin
                num_reg <= pk_reg;
                den_reg <= sum_reg;
            end
            ktssr_pkg::ST_MG:    num_reg <= prod_reg;
            ktssr_pkg::ST_DEN:   den_reg <= num_reg + prod_reg;
            default: ;
        endcase
    end

    // output register, frees the sequencer while a result waits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_pred_reg <= pred_reg;
            m_err_reg  <= err_reg;
            m_exc_reg  <= over_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = OUT_W'({m_err_reg, m_pred_reg});
    assign m_tuser[0] = m_exc_reg;

    // level never exceeds one
    a_level_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= ONE)
        else $error("knowledge level above one");

    // error sum only grows while a row is in work
    a_err_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ktssr_pkg::ST_IDLE) |=> (err_reg >= $past(err_reg)))
        else $error("error sum decreased within a row");

    // a row after exceeded goes straight to the result with predicted zero
    a_skip_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ktssr_pkg::ST_CHECK && over_reg)
        |=> (state_reg == ktssr_pkg::ST_DONE && pred_reg == '0))
        else $error("ignored row not skipped");

    // divider completes only while the sequencer waits for it
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ktssr_pkg::ST_DIV))
        else $error("divider done outside wait state");

endmodule

`default_nettype wire

/* hdl/ktssr_div.sv */
// ktssr_div: restoring fractional divider, floor(num * 2^PROB_BITS / den)
// for num <= den, one quotient bit per cycle; zero divisor gives zero.
// Depends on ktssr_pkg for the control and status structs.
`default_nettype none

module ktssr_div #(
    parameter int PROB_BITS = ktssr_pkg::PROB_BITS_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire  ktssr_pkg::div_ctrl_t   ctrl,
    input  wire  [2*PROB_BITS:0]         num,
    input  wire  [2*PROB_BITS:0]         den,
    output ktssr_pkg::div_stat_t         stat,
    output logic [PROB_BITS:0]           quot
);

    localparam int DW    = 2 * PROB_BITS + 1;
    localparam int RW    = DW + 1;
    localparam int CNT_W = $clog2(PROB_BITS + 1);

    logic [RW-1:0]        rem_reg;
    logic [PROB_BITS:0]   q_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [RW-1:0]        rem_sh;
    logic [RW-1:0]        den_ext;
    logic [RW-1:0]        trial;
    logic                 step_ge;
    logic                 first_ge;
    logic                 den_zero;

    // one compare and subtract step
    always_comb begin
        den_ext  = RW'(den);
        rem_sh   = {rem_reg[RW-2:0], 1'b0};
        trial    = rem_sh - den_ext;
        step_ge  = (rem_sh >= den_ext);
        first_ge = (num >= den);
        den_zero = (den == '0);
    end

    // control: busy flag, bit counter, done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                if (den_zero) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                end
                cnt_reg <= CNT_W'(PROB_BITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: partial remainder and quotient shift register
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            if (den_zero) begin
                q_reg <= '0;
            end else begin
                q_reg <= (PROB_BITS+1)'(first_ge);
            end
            rem_reg <= first_ge ? (RW'(num) - den_ext) : RW'(num);
        end else if (busy_reg) begin
            rem_reg <= step_ge ? trial : rem_sh;
            q_reg   <= {q_reg[PROB_BITS-1:0], step_ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = q_reg;

endmodule

`default_nettype wire
